// ----- sv/assert_macros.svh -----
// Assertion macros shared by the RTL modules of the profile attribution block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PBSA_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define PBSA_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PBSA_ASSERT(lbl, clk, rst, prop, msg)
`define PBSA_ASSERT_RST(lbl, clk, prop, msg)
`endif
`endif

// ----- sv/pbsa_pkg.sv -----
// Types and constants of the profile bin symbol attribution block.
package pbsa_pkg;

  localparam logic [2:0] REQ_CLEAR = 3'd0;
  localparam logic [2:0] REQ_LOAD  = 3'd1;
  localparam logic [2:0] REQ_CALL  = 3'd2;
  localparam logic [2:0] REQ_BIN   = 3'd3;
  localparam logic [2:0] REQ_READ  = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  localparam logic REG_BIN_BASE  = 1'b0;
  localparam logic REG_BIN_SCALE = 1'b1;

  localparam int DIV_W = 72;
  localparam int DSR_W = 32;
  localparam logic [17:0] SPAN_NUM = 18'h20000;
  localparam logic [11:0] LOW12 = 12'hfff;
  localparam logic [47:0] MAX48 = 48'hffff_ffff_ffff;
  localparam logic [31:0] MAX32 = 32'hffff_ffff;

  typedef enum logic [4:0] {
    OP_IDLE, OP_TAKE, OP_CLEAR, OP_LOAD, OP_RES_EMPTY, OP_RES_RANGE, OP_RES_NONE,
    OP_READ_ISSUE, OP_READ_RES, OP_SCAN_RD, OP_SCAN_NEXT, OP_CALL_RD, OP_CALL_UPD,
    OP_DIV_SCALE, OP_BIN_STEP, OP_CUR_RD, OP_SA_TAKE, OP_NX_RD, OP_SKIP, OP_NX_TAKE,
    OP_NX_NONE, OP_MUL, OP_SHARE, OP_ACC, OP_RES_RD, OP_BIN_RES
  } dp_op_t;

  typedef struct packed {
    logic [2:0] req_type;
    logic       empty;
    logic       full;
    logic       eidx_ok;
    logic       scan_more;
    logic       le_addr;
    logic       div_busy;
    logic       cnt_zero;
    logic       cur_ok;
    logic       sa_ge_hi;
    logic       nx_ok;
    logic       rd_le_lo;
    logic       go_on;
  } dp_stat_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  symbol_index;
    logic [31:0] symbol_address;
    logic [47:0] time_credit;
    logic [31:0] call_total;
    logic [31:0] all_ticks;
    logic [31:0] all_calls;
  } res_t;

endpackage

// ----- sv/profile_bin_symbol_attribution_top.sv -----
// Top level of the profile bin symbol attribution block.
//
// Usage: load function start addresses in ascending order, then feed call
// records and histogram bins; each request beat on the slave side returns one
// result beat on the master side. s_tuser carries the request type, m_tuser
// the status. Registers bin_base (index 0) and bin_scale (index 1) are
// written through cfg_we/cfg_index/cfg_data; the user must write them only
// while idle, as the block does not enforce it. A write restarts the bin
// walk at bin_base. A call record scans the table for its symbol; a bin
// runs the scale division, then one share division per overlapped symbol:
// every quotient comes from one shared 72-step restoring divider, one bit a
// cycle.
// One request is in work at a time; s_tready is high only in idle, and a new
// request is taken while the previous result still waits in the output
// register. When the receiver stalls, the finished result of the next request
// is held until the output register frees up.
// Reset empties the table (fill count only, no clearing pass), zeroes the sums
// and sets bin_base 0, bin_scale 0xffff.
module profile_bin_symbol_attribution_top #(
  parameter int MAX_SYMBOLS = 256
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [31:0]  cfg_data,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [71:0]  s_tdata,   // address[31:0], count[63:32], entry_index[71:64]
  input  logic [2:0]   s_tuser,   // req_type[2:0]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [183:0] m_tdata,   // symbol_index[7:0], symbol_address[39:8],
                                  // time_credit[87:40], call_total[119:88],
                                  // all_ticks[151:120], all_calls[183:152]
  output logic [1:0]   m_tuser    // status[1:0]
);

  pbsa_pkg::dp_op_t   op;
  pbsa_pkg::dp_stat_t stat;
  pbsa_pkg::res_t     res;

  pbsa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .op       (op)
  );

  pbsa_datapath #(.MAX_SYMBOLS(MAX_SYMBOLS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (s_tdata),
    .in_type   (s_tuser),
    .op        (op),
    .stat      (stat),
    .res       (res)
  );

  // pack the result beat, first field lowest
  assign m_tuser = res.status;
  assign m_tdata = {res.all_calls, res.all_ticks, res.call_total, res.time_credit,
                    res.symbol_address, res.symbol_index};

endmodule

// ----- sv/pbsa_divider.sv -----
// Restoring divider, one quotient bit per cycle, shared by the bin step and share math.
`include "assert_macros.svh"
module pbsa_divider (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [pbsa_pkg::DIV_W-1:0]    dividend,
  input  logic [pbsa_pkg::DSR_W-1:0]    divisor,
  output logic                          busy,
  output logic [pbsa_pkg::DIV_W-1:0]    quot,
  output logic [pbsa_pkg::DSR_W-1:0]    rem
);

  localparam int CNT_W = $clog2(pbsa_pkg::DIV_W + 1);

  logic [pbsa_pkg::DSR_W-1:0] dsr;
  logic [CNT_W-1:0]           cnt;
  logic [pbsa_pkg::DSR_W:0]   trial;
  logic                       ge;

  assign trial = {rem, quot[pbsa_pkg::DIV_W-1]};
  assign ge    = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      quot <= dividend;
      dsr  <= divisor;
      rem  <= '0;
      cnt  <= CNT_W'(pbsa_pkg::DIV_W);
      busy <= 1'b1;
    end else if (busy) begin
      // shift the quotient bit in where the dividend bit left
      rem  <= ge ? pbsa_pkg::DSR_W'(trial - {1'b0, dsr}) : trial[pbsa_pkg::DSR_W-1:0];
      quot <= {quot[pbsa_pkg::DIV_W-2:0], ge};
      cnt  <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  `PBSA_ASSERT(a_div_nonzero, clk, rst, busy |-> dsr != '0, "divider runs with zero divisor")
  `PBSA_ASSERT_RST(a_div_reset, clk, rst |=> !busy, "divider busy after reset")

endmodule

// ----- sv/pbsa_datapath.sv -----
// Datapath: symbol memories, walk registers, bin stepping and share arithmetic.
`include "assert_macros.svh"
module pbsa_datapath #(
  parameter int MAX_SYMBOLS = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [31:0]       cfg_data,
  input  logic [71:0]       in_data,
  input  logic [2:0]        in_type,
  input  pbsa_pkg::dp_op_t  op,
  output pbsa_pkg::dp_stat_t stat,
  output pbsa_pkg::res_t    res
);

  localparam int IW = $clog2(MAX_SYMBOLS);
  localparam int CW = $clog2(MAX_SYMBOLS + 1);

  logic [31:0] start_mem [MAX_SYMBOLS];
  logic [47:0] time_mem  [MAX_SYMBOLS];
  logic [31:0] calls_mem [MAX_SYMBOLS];

  logic [2:0]  req_type;
  logic [31:0] addr, cnt;
  logic [7:0]  eidx;
  logic [CW-1:0] n, k, cur;
  logic [IW-1:0] resume;
  logic [31:0] tick_sum, call_sum, bin_base, bin_end;
  logic [15:0] bin_scale;
  logic signed [17:0] bin_rem;
  logic [31:0] lo, hi, len, sa, snx;
  logic        nxv;
  logic [63:0] q;
  logic [31:0] rd_start, rd_calls;
  logic [47:0] rd_time;

  // divider
  logic                       div_start, div_busy;
  logic [pbsa_pkg::DIV_W-1:0] div_dvd, quot;
  logic [pbsa_pkg::DSR_W-1:0] div_dsr, drem;

  logic [CW-1:0] km1, cur1;
  logic [16:0]   s_inc, s_eff;
  logic          has_r, adjust;
  logic [31:0]   inc, hi_new, len_raw;
  logic signed [18:0] incr, rem_sum, rem_adj;
  logic [31:0]   endp, begp, ov;
  logic [71:0]   n72;
  logic [47:0]   share, time_new;
  logic [48:0]   tsum;
  logic [32:0]   csum, call_sum_sum, tick_sum_sum;
  logic [31:0]   calls_new, call_sum_new, tick_sum_new;
  logic [IW-1:0] ra;
  logic          rd_en;

  assign km1  = k - 1'b1;
  assign cur1 = cur + 1'b1;

  // effective scale: low twelve bits all ones rounds up, floor of two
  assign s_inc = (bin_scale[11:0] == pbsa_pkg::LOW12) ? {1'b0, bin_scale} + 17'd1
                                                      : {1'b0, bin_scale};
  assign s_eff = (s_inc < 17'd2) ? 17'd2 : s_inc;

  assign has_r   = drem != '0;
  assign inc     = quot[31:0] + {31'd0, has_r};
  assign incr    = has_r ? signed'({2'b00, drem[16:0]}) - signed'({2'b00, s_eff}) : '0;
  assign rem_sum = signed'({bin_rem[17], bin_rem}) + incr;
  assign rem_adj = rem_sum + signed'({2'b00, s_eff});
  assign adjust  = rem_adj[18] || (rem_adj == '0);
  assign hi_new  = bin_end + inc - {31'd0, adjust};
  assign len_raw = hi_new - bin_end;

  assign endp = (nxv && (snx < hi)) ? snx : hi;
  assign begp = (sa > lo) ? sa : lo;
  assign ov   = endp - begp;
  assign n72  = (72'(q) << 6) + (72'(q) << 5) + (72'(q) << 2) + 72'(len[31:1]);

  assign share    = (|quot[71:48]) ? pbsa_pkg::MAX48 : quot[47:0];
  assign tsum     = {1'b0, rd_time} + {1'b0, share};
  assign time_new = tsum[48] ? pbsa_pkg::MAX48 : tsum[47:0];
  assign csum     = {1'b0, rd_calls} + {1'b0, cnt};
  assign calls_new = csum[32] ? pbsa_pkg::MAX32 : csum[31:0];
  assign call_sum_sum = {1'b0, call_sum} + {1'b0, cnt};
  assign call_sum_new = call_sum_sum[32] ? pbsa_pkg::MAX32 : call_sum_sum[31:0];
  assign tick_sum_sum = {1'b0, tick_sum} + {1'b0, cnt};
  assign tick_sum_new = tick_sum_sum[32] ? pbsa_pkg::MAX32 : tick_sum_sum[31:0];

  assign div_start = (op == pbsa_pkg::OP_DIV_SCALE) || (op == pbsa_pkg::OP_SHARE);
  assign div_dvd   = (op == pbsa_pkg::OP_SHARE) ? n72 : 72'(pbsa_pkg::SPAN_NUM);
  assign div_dsr   = (op == pbsa_pkg::OP_SHARE) ? len : 32'(s_eff);

  pbsa_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .busy     (div_busy),
    .quot     (quot),
    .rem      (drem)
  );

  always_comb begin
    rd_en = 1'b1;
    ra    = '0;
    unique case (op)
      pbsa_pkg::OP_SCAN_RD:    ra = k[IW-1:0];
      pbsa_pkg::OP_CALL_RD:    ra = km1[IW-1:0];
      pbsa_pkg::OP_READ_ISSUE: ra = IW'(eidx);
      pbsa_pkg::OP_CUR_RD,
      pbsa_pkg::OP_MUL:        ra = cur[IW-1:0];
      pbsa_pkg::OP_NX_RD:      ra = cur1[IW-1:0];
      pbsa_pkg::OP_RES_RD:     ra = resume;
      default:                 rd_en = 1'b0;
    endcase
  end

  always_comb begin
    stat.req_type  = req_type;
    stat.empty     = n == '0;
    stat.full      = n >= CW'(MAX_SYMBOLS);
    stat.eidx_ok   = 32'(eidx) < 32'(n);
    stat.scan_more = k < n;
    stat.le_addr   = rd_start <= addr;
    stat.div_busy  = div_busy;
    stat.cnt_zero  = cnt == '0;
    stat.cur_ok    = cur < n;
    stat.sa_ge_hi  = rd_start >= hi;
    stat.nx_ok     = cur1 < n;
    stat.rd_le_lo  = rd_start <= lo;
    stat.go_on     = nxv && (snx < hi);
  end

  // memories
  always_ff @(posedge clk) begin
    if (op == pbsa_pkg::OP_LOAD && !stat.full) begin
      start_mem[n[IW-1:0]] <= addr;
      time_mem[n[IW-1:0]]  <= '0;
      calls_mem[n[IW-1:0]] <= '0;
    end
    if (op == pbsa_pkg::OP_CALL_UPD) begin
      calls_mem[km1[IW-1:0]] <= calls_new;
    end
    if (op == pbsa_pkg::OP_ACC) begin
      time_mem[cur[IW-1:0]] <= time_new;
    end
    if (rd_en) begin
      rd_start <= start_mem[ra];
      rd_time  <= time_mem[ra];
      rd_calls <= calls_mem[ra];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n         <= '0;
      tick_sum  <= '0;
      call_sum  <= '0;
      bin_base  <= '0;
      bin_scale <= 16'hffff;
      bin_end   <= '0;
      bin_rem   <= '0;
      resume    <= '0;
    end else begin
      unique case (op)
        pbsa_pkg::OP_TAKE: begin
          req_type <= in_type;
          addr     <= in_data[31:0];
          cnt      <= in_data[63:32];
          eidx     <= in_data[71:64];
          k        <= CW'(1);
          cur      <= CW'(resume);
        end
        pbsa_pkg::OP_CLEAR: begin
          n        <= '0;
          tick_sum <= '0;
          call_sum <= '0;
          bin_end  <= bin_base;
          bin_rem  <= '0;
          resume   <= '0;
          res      <= '{pbsa_pkg::ST_OK, 8'd0, 32'd0, 48'd0, 32'd0, 32'd0, 32'd0};
        end
        pbsa_pkg::OP_LOAD: begin
          if (stat.full) begin
            res <= '{pbsa_pkg::ST_FULL, 8'd0, 32'd0, 48'd0, 32'd0, tick_sum, call_sum};
          end else begin
            n   <= n + 1'b1;
            res <= '{pbsa_pkg::ST_OK, 8'(n), addr, 48'd0, 32'd0, tick_sum, call_sum};
          end
        end
        pbsa_pkg::OP_RES_EMPTY:
          res <= '{pbsa_pkg::ST_EMPTY, 8'd0, 32'd0, 48'd0, 32'd0, tick_sum, call_sum};
        pbsa_pkg::OP_RES_RANGE:
          res <= '{pbsa_pkg::ST_RANGE, eidx, 32'd0, 48'd0, 32'd0, tick_sum, call_sum};
        pbsa_pkg::OP_RES_NONE:
          res <= '{pbsa_pkg::ST_OK, 8'd0, 32'd0, 48'd0, 32'd0, tick_sum, call_sum};
        pbsa_pkg::OP_READ_RES:
          res <= '{pbsa_pkg::ST_OK, eidx, rd_start, rd_time, rd_calls, tick_sum, call_sum};
        pbsa_pkg::OP_SCAN_NEXT: k <= k + 1'b1;
        pbsa_pkg::OP_CALL_UPD: begin
          call_sum <= call_sum_new;
          res <= '{pbsa_pkg::ST_OK, 8'(km1), rd_start, rd_time, calls_new, tick_sum,
                   call_sum_new};
        end
        pbsa_pkg::OP_BIN_STEP: begin
          lo      <= bin_end;
          hi      <= hi_new;
          len     <= (len_raw == '0) ? 32'd1 : len_raw;
          bin_end <= hi_new;
          bin_rem <= adjust ? 18'(rem_adj) : 18'(rem_sum);
          if (cnt != '0) begin
            tick_sum <= tick_sum_new;
          end
        end
        pbsa_pkg::OP_SA_TAKE: sa <= rd_start;
        pbsa_pkg::OP_SKIP: begin
          cur <= cur1;
          sa  <= rd_start;
        end
        pbsa_pkg::OP_NX_TAKE: begin
          snx <= rd_start;
          nxv <= 1'b1;
        end
        pbsa_pkg::OP_NX_NONE: nxv <= 1'b0;
        pbsa_pkg::OP_MUL: q <= 64'(ov) * 64'(cnt);
        pbsa_pkg::OP_ACC: begin
          // advance to the next symbol, or park the walk on this one
          if (stat.go_on) begin
            cur <= cur1;
            sa  <= snx;
          end else begin
            resume <= cur[IW-1:0];
          end
        end
        pbsa_pkg::OP_BIN_RES:
          res <= '{pbsa_pkg::ST_OK, 8'(resume), rd_start, rd_time, rd_calls, tick_sum,
                   call_sum};
        default: ;
      endcase
      if (cfg_we) begin
        if (cfg_index == pbsa_pkg::REG_BIN_BASE) begin
          bin_base <= cfg_data;
          bin_end  <= cfg_data;
        end else begin
          bin_scale <= cfg_data[15:0];
          bin_end   <= bin_base;
        end
        bin_rem <= '0;
        resume  <= '0;
      end
    end
  end

  `PBSA_ASSERT(a_fill_bound, clk, rst, n <= CW'(MAX_SYMBOLS), "fill count past table")
  `PBSA_ASSERT(a_resume_bound, clk, rst, n != '0 |-> CW'(resume) < n,
               "walk parked beyond loaded symbols")

endmodule

// ----- sv/pbsa_ctrl.sv -----
// Controller state machine sequencing the datapath for each request.
`include "assert_macros.svh"
module pbsa_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  output logic               m_tvalid,
  input  logic               m_tready,
  input  pbsa_pkg::dp_stat_t stat,
  output pbsa_pkg::dp_op_t   op
);

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_CLEAR, S_LOAD, S_EMPTY, S_RANGE, S_NONE, S_RD_RES,
    S_SCAN_Q, S_SCAN_CHK, S_CALL_UPD, S_DIV_W, S_BIN_CHK, S_SA, S_SKQ, S_SKCHK,
    S_MUL, S_SHARE, S_SHW, S_BQ, S_BCHK, S_RES_Q, S_RES_BIN, S_DIV_S
  } state_t;

  state_t state, state_next;
  logic   out_free, emit;

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = state == S_IDLE;

  always_comb begin
    state_next = state;
    op         = pbsa_pkg::OP_IDLE;
    emit       = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          op         = pbsa_pkg::OP_TAKE;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (stat.req_type)
          pbsa_pkg::REQ_CLEAR: state_next = S_CLEAR;
          pbsa_pkg::REQ_LOAD:  state_next = S_LOAD;
          pbsa_pkg::REQ_CALL:  state_next = stat.empty ? S_EMPTY : S_SCAN_Q;
          pbsa_pkg::REQ_BIN:   state_next = S_DIV_S;
          pbsa_pkg::REQ_READ: begin
            if (stat.eidx_ok) begin
              op         = pbsa_pkg::OP_READ_ISSUE;
              state_next = S_RD_RES;
            end else begin
              state_next = S_RANGE;
            end
          end
          default: state_next = S_NONE;
        endcase
      end
      S_CLEAR, S_LOAD, S_EMPTY, S_RANGE, S_NONE, S_RD_RES, S_CALL_UPD, S_RES_BIN: begin
        // hold the finished result until the output register frees up
        if (out_free) begin
          emit       = 1'b1;
          state_next = S_IDLE;
          unique case (state)
            S_CLEAR:    op = pbsa_pkg::OP_CLEAR;
            S_LOAD:     op = pbsa_pkg::OP_LOAD;
            S_EMPTY:    op = pbsa_pkg::OP_RES_EMPTY;
            S_RANGE:    op = pbsa_pkg::OP_RES_RANGE;
            S_RD_RES:   op = pbsa_pkg::OP_READ_RES;
            S_CALL_UPD: op = pbsa_pkg::OP_CALL_UPD;
            S_RES_BIN:  op = pbsa_pkg::OP_BIN_RES;
            default:    op = pbsa_pkg::OP_RES_NONE;
          endcase
        end
      end
      S_SCAN_Q: begin
        if (stat.scan_more) begin
          op         = pbsa_pkg::OP_SCAN_RD;
          state_next = S_SCAN_CHK;
        end else begin
          op         = pbsa_pkg::OP_CALL_RD;
          state_next = S_CALL_UPD;
        end
      end
      S_SCAN_CHK: begin
        if (stat.le_addr) begin
          op         = pbsa_pkg::OP_SCAN_NEXT;
          state_next = S_SCAN_Q;
        end else begin
          op         = pbsa_pkg::OP_CALL_RD;
          state_next = S_CALL_UPD;
        end
      end
      S_DIV_S: begin
        op         = pbsa_pkg::OP_DIV_SCALE;
        state_next = S_DIV_W;
      end
      S_DIV_W: begin
        if (!stat.div_busy) begin
          op         = pbsa_pkg::OP_BIN_STEP;
          state_next = S_BIN_CHK;
        end
      end
      S_BIN_CHK: begin
        if (!stat.cnt_zero && !stat.empty && stat.cur_ok) begin
          op         = pbsa_pkg::OP_CUR_RD;
          state_next = S_SA;
        end else begin
          state_next = S_RES_Q;
        end
      end
      S_SA: begin
        if (stat.sa_ge_hi) begin
          state_next = S_RES_Q;
        end else begin
          op         = pbsa_pkg::OP_SA_TAKE;
          state_next = S_SKQ;
        end
      end
      S_SKQ: begin
        if (stat.nx_ok) begin
          op         = pbsa_pkg::OP_NX_RD;
          state_next = S_SKCHK;
        end else begin
          op         = pbsa_pkg::OP_NX_NONE;
          state_next = S_MUL;
        end
      end
      S_SKCHK: begin
        if (stat.rd_le_lo) begin
          op         = pbsa_pkg::OP_SKIP;
          state_next = S_SKQ;
        end else begin
          op         = pbsa_pkg::OP_NX_TAKE;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        op         = pbsa_pkg::OP_MUL;
        state_next = S_SHARE;
      end
      S_SHARE: begin
        op         = pbsa_pkg::OP_SHARE;
        state_next = S_SHW;
      end
      S_SHW: begin
        if (!stat.div_busy) begin
          op         = pbsa_pkg::OP_ACC;
          state_next = stat.go_on ? S_BQ : S_RES_Q;
        end
      end
      S_BQ: begin
        if (stat.nx_ok) begin
          op         = pbsa_pkg::OP_NX_RD;
          state_next = S_BCHK;
        end else begin
          op         = pbsa_pkg::OP_NX_NONE;
          state_next = S_MUL;
        end
      end
      S_BCHK: begin
        op         = pbsa_pkg::OP_NX_TAKE;
        state_next = S_MUL;
      end
      S_RES_Q: begin
        if (stat.empty) begin
          state_next = S_EMPTY;
        end else begin
          op         = pbsa_pkg::OP_RES_RD;
          state_next = S_RES_BIN;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  `PBSA_ASSERT(a_emit_idle, clk, rst, $rose(m_tvalid) |-> state == S_IDLE,
               "result shown outside the return to idle")
  `PBSA_ASSERT_RST(a_reset_out, clk, rst |=> !m_tvalid, "result valid after reset")

endmodule
